@@ rtl/wbct_pkg.sv @@
// Package for the work/break cycle timer: widths, mode and register codes,
// the configuration and state records, and small helpers.
// No dependencies; every other file of the block but wbct_in_if imports it.
package wbct_pkg;

  // Width of the countdown seconds.
  localparam int SECONDS_BITS = 16;

  // Widths of the configuration port and the internal counters.
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 20;
  localparam int IDLE_BITS     = 21;

  localparam logic [IDLE_BITS-1:0] IDLE_MAX  = '1;
  localparam logic [15:0]          TICK_MAX  = '1;
  localparam logic [15:0]          PRESS_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_WORK_SECONDS   = 16'd1500;
  localparam logic [15:0] RST_SHORT_SECONDS  = 16'd300;
  localparam logic [15:0] RST_LONG_SECONDS   = 16'd900;
  localparam logic [7:0]  RST_CYCLES_PER_LB  = 8'd4;
  localparam logic [15:0] RST_HOLD_LIMIT     = 16'd1000;
  localparam logic [15:0] RST_TICKS_PER_SEC  = 16'd1000;
  localparam logic [19:0] RST_DISPLAY_TMO_MS = 20'd30000;
  localparam logic [19:0] RST_DOZE_DELAY     = 20'd10000;

  // Timer modes.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORK   = 3'd1,
    MODE_SHORT  = 3'd2,
    MODE_LONG   = 3'd3,
    MODE_PAUSED = 3'd4
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WORK_SECONDS   = 4'd0,
    REG_SHORT_SECONDS  = 4'd1,
    REG_LONG_SECONDS   = 4'd2,
    REG_CYCLES_PER_LB  = 4'd3,
    REG_HOLD_LIMIT     = 4'd4,
    REG_TICKS_PER_SEC  = 4'd5,
    REG_DISPLAY_TMO_MS = 4'd6,
    REG_DOZE_DELAY     = 4'd7
  } cfg_reg_t;

  // Current configuration as seen by the step logic.
  typedef struct packed {
    logic [15:0] work_seconds;
    logic [15:0] short_break_seconds;
    logic [15:0] long_break_seconds;
    logic [7:0]  cycles_per_long_break;
    logic [15:0] hold_limit_ticks;
    logic [15:0] ticks_per_second;
    logic [19:0] screen_off_ticks;
    logic [19:0] doze_delay_ticks;
  } cfg_t;

  // Timer state carried from one tick to the next.
  typedef struct packed {
    mode_t                   mode;
    mode_t                   mode_before_pause;
    logic [SECONDS_BITS-1:0] seconds;
    logic [15:0]             work_count;
    logic [7:0]              lb_phase;
    logic                    touch_prev;
    logic [15:0]             press_ticks;
    logic [15:0]             second_ticks;
    logic [IDLE_BITS-1:0]    idle_ticks;
    logic                    display_on;
    logic                    asleep;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [2:0]              mode;
    logic [SECONDS_BITS-1:0] seconds_left;
    logic [15:0]             cycles_done;
    logic                    display_enabled;
    logic                    asleep;
    logic                    redraw;
  } result_t;

  // Fit a 16-bit period length into the seconds counter.
  function automatic logic [SECONDS_BITS-1:0] to_secs(input logic [15:0] v);
    return SECONDS_BITS'(v);
  endfunction

  // Work, short break and long break count down; idle and paused do not.
  function automatic logic is_running(input mode_t m);
    return (m == MODE_WORK) || (m == MODE_SHORT) || (m == MODE_LONG);
  endfunction

endpackage

@@ rtl/wbct_in_if.sv @@
// Input channel of the cycle timer: one millisecond tick with the touch level.
// Depends on nothing but the handshake convention valid/ready.
interface wbct_in_if ();
  logic valid;
  logic ready;
  logic touch_level;

  modport source (output valid, output touch_level, input ready);
  modport sink   (input valid, input touch_level, output ready);
endinterface

@@ rtl/wbct_out_if.sv @@
// Result channel of the cycle timer: mode, countdown and status per tick.
// Depends on wbct_pkg for the seconds width.
interface wbct_out_if import wbct_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              mode;
  logic [SECONDS_BITS-1:0] seconds_left;
  logic [15:0]             cycles_done;
  logic                    display_enabled;
  logic                    asleep;
  logic                    redraw;

  modport source (output valid, output mode, output seconds_left, output cycles_done,
                  output display_enabled, output asleep, output redraw, input ready);
  modport sink   (input valid, input mode, input seconds_left, input cycles_done,
                  input display_enabled, input asleep, input redraw, output ready);
endinterface

@@ rtl/wbct_cfg_if.sv @@
// Configuration write channel of the cycle timer: register index and data.
// Depends on wbct_pkg for the index and data widths.
interface wbct_cfg_if import wbct_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/wbct_cfg_regs.sv @@
// Configuration register file of the cycle timer.
// Depends on wbct_pkg and wbct_cfg_if.
module wbct_cfg_regs import wbct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wbct_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  // Decode the register index of a write request.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WORK_SECONDS:   cfg_nxt.work_seconds          = cfg_ch.data[15:0];
        REG_SHORT_SECONDS:  cfg_nxt.short_break_seconds   = cfg_ch.data[15:0];
        REG_LONG_SECONDS:   cfg_nxt.long_break_seconds    = cfg_ch.data[15:0];
        REG_CYCLES_PER_LB:  cfg_nxt.cycles_per_long_break = cfg_ch.data[7:0];
        REG_HOLD_LIMIT:     cfg_nxt.hold_limit_ticks      = cfg_ch.data[15:0];
        REG_TICKS_PER_SEC:  cfg_nxt.ticks_per_second      = cfg_ch.data[15:0];
        REG_DISPLAY_TMO_MS: cfg_nxt.screen_off_ticks      = cfg_ch.data[19:0];
        REG_DOZE_DELAY:     cfg_nxt.doze_delay_ticks      = cfg_ch.data[19:0];
        default: ;
      endcase
    end
  end

  // Register storage with power-on defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.work_seconds          <= RST_WORK_SECONDS;
      cfg_r.short_break_seconds   <= RST_SHORT_SECONDS;
      cfg_r.long_break_seconds    <= RST_LONG_SECONDS;
      cfg_r.cycles_per_long_break <= RST_CYCLES_PER_LB;
      cfg_r.hold_limit_ticks      <= RST_HOLD_LIMIT;
      cfg_r.ticks_per_second      <= RST_TICKS_PER_SEC;
      cfg_r.screen_off_ticks      <= RST_DISPLAY_TMO_MS;
      cfg_r.doze_delay_ticks      <= RST_DOZE_DELAY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/wbct_step.sv @@
// Next-state logic of the cycle timer for one millisecond tick.
// Depends on wbct_pkg; purely combinational.
module wbct_step import wbct_pkg::*; (
  input  state_t  state,
  input  cfg_t    cfg,
  input  logic    touch_level,
  output state_t  state_nxt,
  output result_t result
);

  logic                    awake;
  logic                    rise;
  logic                    fall;
  logic [SECONDS_BITS-1:0] secs_dec;
  logic [7:0]              phase_inc;
  logic [IDLE_BITS-1:0]    sleep_limit;

  assign awake       = !state.asleep || touch_level;
  assign rise        = touch_level && !state.touch_prev;
  assign fall        = !touch_level && state.touch_prev;
  assign sleep_limit = IDLE_BITS'(cfg.screen_off_ticks) + IDLE_BITS'(cfg.doze_delay_ticks);

  always_comb begin
    state_nxt = state;
    secs_dec  = '0;
    phase_inc = '0;

    // A touch while asleep wakes the block and restarts the idle timing.
    if (state.asleep && touch_level) begin
      state_nxt.asleep       = 1'b0;
      state_nxt.display_on   = 1'b1;
      state_nxt.idle_ticks   = '0;
      state_nxt.second_ticks = '0;
    end

    if (awake) begin
      // Saturating time counters.
      if (state.touch_prev && state_nxt.press_ticks != PRESS_MAX) begin
        state_nxt.press_ticks = state_nxt.press_ticks + 16'd1;
      end
      if (state_nxt.second_ticks != TICK_MAX) begin
        state_nxt.second_ticks = state_nxt.second_ticks + 16'd1;
      end
      if (state_nxt.idle_ticks != IDLE_MAX) begin
        state_nxt.idle_ticks = state_nxt.idle_ticks + IDLE_BITS'(1);
      end

      // Touch edges: a press starts timing, a release acts on its length.
      if (rise) begin
        state_nxt.press_ticks = '0;
        state_nxt.display_on  = 1'b1;
        state_nxt.idle_ticks  = '0;
      end else if (fall) begin
        if (state_nxt.press_ticks < cfg.hold_limit_ticks) begin
          if (state_nxt.mode == MODE_IDLE) begin
            state_nxt.mode         = MODE_WORK;
            state_nxt.seconds      = to_secs(cfg.work_seconds);
            state_nxt.second_ticks = '0;
          end else if (is_running(state_nxt.mode)) begin
            state_nxt.mode_before_pause = state_nxt.mode;
            state_nxt.mode              = MODE_PAUSED;
          end else if (state_nxt.seconds == '0) begin
            state_nxt.mode    = MODE_IDLE;
            state_nxt.seconds = to_secs(cfg.work_seconds);
          end else begin
            state_nxt.mode = state_nxt.mode_before_pause;
          end
        end else begin
          state_nxt.mode       = MODE_IDLE;
          state_nxt.seconds    = to_secs(cfg.work_seconds);
          state_nxt.work_count = '0;
          state_nxt.lb_phase   = '0;
        end
        state_nxt.display_on = 1'b1;
        state_nxt.idle_ticks = '0;
      end
      state_nxt.touch_prev = touch_level;

      // One countdown second per tick interval.
      if (state_nxt.second_ticks >= cfg.ticks_per_second) begin
        state_nxt.second_ticks = '0;
        if (is_running(state_nxt.mode)) begin
          secs_dec = (state_nxt.seconds != '0) ? state_nxt.seconds - SECONDS_BITS'(1)
                                               : state_nxt.seconds;
          state_nxt.seconds = secs_dec;
          if (secs_dec == '0) begin
            if (state_nxt.mode == MODE_WORK) begin
              phase_inc            = state_nxt.lb_phase + 8'd1;
              state_nxt.work_count = state_nxt.work_count + 16'd1;
              if (phase_inc >= cfg.cycles_per_long_break) begin
                state_nxt.lb_phase = '0;
                state_nxt.mode     = MODE_LONG;
                state_nxt.seconds  = to_secs(cfg.long_break_seconds);
              end else begin
                state_nxt.lb_phase = phase_inc;
                state_nxt.mode     = MODE_SHORT;
                state_nxt.seconds  = to_secs(cfg.short_break_seconds);
              end
            end else begin
              state_nxt.mode    = MODE_WORK;
              state_nxt.seconds = to_secs(cfg.work_seconds);
            end
          end
        end
      end

      // Display timeout, then sleep when nothing is running.
      if (state_nxt.display_on &&
          state_nxt.idle_ticks >= IDLE_BITS'(cfg.screen_off_ticks)) begin
        state_nxt.display_on = 1'b0;
      end
      if (!state_nxt.display_on &&
          (state_nxt.mode == MODE_IDLE || state_nxt.mode == MODE_PAUSED) &&
          state_nxt.idle_ticks >= sleep_limit) begin
        state_nxt.asleep = 1'b1;
      end
    end
  end

  // Result fields come from the updated state.
  always_comb begin
    result.mode            = state_nxt.mode;
    result.seconds_left    = state_nxt.seconds;
    result.cycles_done     = state_nxt.work_count;
    result.display_enabled = state_nxt.display_on;
    result.asleep          = state_nxt.asleep;
    result.redraw          = (state_nxt.mode != state.mode) ||
                             (state_nxt.seconds != state.seconds);
  end

endmodule

@@ rtl/work_break_cycle_timer_core.sv @@
// Work/break cycle timer. Each accepted input request is one millisecond tick
// with the sampled touch level, and yields exactly one result request with the
// mode, the seconds left, the completed work periods and the display and sleep
// flags. The state update for a tick is a single pass of combinational logic
// into the state registers, and its result is registered and shown on the next
// cycle, so one tick can be accepted in every cycle while the result register
// is free or being taken. Configuration writes take effect in the cycle after
// the write request and should be made while no result is pending.
module work_break_cycle_timer_core import wbct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wbct_in_if.sink     in_ch,
  wbct_out_if.source  out_ch,
  wbct_cfg_if.sink    cfg_ch
);

  cfg_t    cfg;
  state_t  state_r;
  state_t  state_nxt;
  result_t step_res;
  result_t result_r;
  logic    out_valid_r;
  logic    in_fire;
  logic    out_fire;

  // Configuration registers.
  wbct_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Per-tick next-state logic.
  wbct_step u_step (
    .state       (state_r),
    .cfg         (cfg),
    .touch_level (in_ch.touch_level),
    .state_nxt   (state_nxt),
    .result      (step_res)
  );

  // Take a tick whenever the result register is empty or being emptied.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // Timer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode              <= MODE_IDLE;
      state_r.mode_before_pause <= MODE_IDLE;
      state_r.seconds           <= to_secs(RST_WORK_SECONDS);
      state_r.work_count        <= '0;
      state_r.lb_phase          <= '0;
      state_r.touch_prev        <= 1'b0;
      state_r.press_ticks       <= '0;
      state_r.second_ticks      <= '0;
      state_r.idle_ticks        <= '0;
      state_r.display_on        <= 1'b1;
      state_r.asleep            <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= step_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.mode            = result_r.mode;
  assign out_ch.seconds_left    = result_r.seconds_left;
  assign out_ch.cycles_done     = result_r.cycles_done;
  assign out_ch.display_enabled = result_r.display_enabled;
  assign out_ch.asleep          = result_r.asleep;
  assign out_ch.redraw          = result_r.redraw;

endmodule
